>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Both assume signals clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

>>> hw/rtl/e2q_pkg.sv
// ----------------------------------------------------------------------------
// e2q_pkg: shared constants and helpers
// Fixed-point constants, the CORDIC arctangent table and latency figures.
// ----------------------------------------------------------------------------
package e2q_pkg;
	localparam int ANGLE_WIDTH_DEF = 16;
	localparam int COMP_FRAC_DEF = 14;
	localparam int CORDIC_STEPS_DEF = 16;

	localparam int ZW = 37;
	localparam int XW = 33;
	localparam int SCW = 32;

	localparam longint PI_Q32 = 64'sd13493037705;
	localparam longint TWO_PI_Q32 = 64'sd26986075409;
	localparam longint HALF_PI_Q32 = 64'sd6746518852;
	localparam longint GAIN_Q30 = 64'sd652032874;

	localparam int MERGE_LAT = 3;

	// Angle magnitude after scaling to Q32 needs this many compare-subtract steps.
	function automatic int red_stages(input int w);
		red_stages = (w > 16) ? w - 15 : 1;
	endfunction

	function automatic int lane_latency(input int w, input int steps);
		lane_latency = 3 + red_stages(w) + steps;
	endfunction

	function automatic logic signed [ZW-1:0] atan_q32(input int i);
		logic signed [ZW-1:0] v;
		case (i)
			0: v = ZW'(64'sd3373259426);
			1: v = ZW'(64'sd1991351318);
			2: v = ZW'(64'sd1052175346);
			3: v = ZW'(64'sd534100635);
			4: v = ZW'(64'sd268086748);
			5: v = ZW'(64'sd134164847);
			6: v = ZW'(64'sd67103403);
			7: v = ZW'(64'sd33553749);
			8: v = ZW'(64'sd16777131);
			9: v = ZW'(64'sd8388597);
			10: v = ZW'(64'sd4194303);
			default: v = (i > 32) ? '0 : (ZW'(1) <<< (32 - i));
		endcase
		return v;
	endfunction
endpackage

>>> hw/rtl/e2q_sincos.sv
// ----------------------------------------------------------------------------
// e2q_sincos: half-angle sine and cosine lane
// Range reduction by pipelined compare-subtract, quadrant fold, then one
// CORDIC rotation per pipeline stage. Results are Q30.
// ----------------------------------------------------------------------------
module e2q_sincos #(
	parameter int ANGLE_WIDTH = e2q_pkg::ANGLE_WIDTH_DEF,
	parameter int CORDIC_STEPS = e2q_pkg::CORDIC_STEPS_DEF
) (
	input  logic clk,
	input  logic en,
	input  logic signed [ANGLE_WIDTH-1:0] angle,
	output logic signed [e2q_pkg::SCW-1:0] cos_o,
	output logic signed [e2q_pkg::SCW-1:0] sin_o
);
	import e2q_pkg::*;

	localparam int NR = red_stages(ANGLE_WIDTH);
	localparam int RW = (ANGLE_WIDTH + 20 > 36) ? ANGLE_WIDTH + 20 : 36;

	logic [ANGLE_WIDTH-1:0] abs_angle;
	logic [RW-1:0] mag_s [NR+1];
	logic neg_s [NR+1];
	logic signed [ZW-1:0] rem;
	logic signed [ZW-1:0] wrap;
	logic signed [ZW-1:0] wrap_q;
	logic signed [ZW-1:0] fold;
	logic fold_neg;
	logic signed [XW-1:0] x_c [CORDIC_STEPS+1];
	logic signed [XW-1:0] y_c [CORDIC_STEPS+1];
	logic signed [ZW-1:0] z_c [CORDIC_STEPS+1];
	logic ng_c [CORDIC_STEPS+1];

	assign abs_angle = angle[ANGLE_WIDTH-1] ? -angle : angle;

	// The half angle in Q13 scaled by 2^19 lands in Q32.
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s[0] <= angle[ANGLE_WIDTH-1];
			mag_s[0] <= RW'(abs_angle) << 19;
		end
	end

	for (genvar k = 0; k < NR; k++) begin : g_red
		localparam logic [RW-1:0] DIV = RW'(TWO_PI_Q32) << (NR - 1 - k);
		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[k+1] <= neg_s[k];
				mag_s[k+1] <= (mag_s[k] >= DIV) ? mag_s[k] - DIV : mag_s[k];
			end
		end
	end

	// The remainder keeps the sign of the dividend.
	always_comb begin
		rem = {1'b0, mag_s[NR][ZW-2:0]};
		if (neg_s[NR])
			rem = -rem;
		wrap = rem;
		if (rem > ZW'(PI_Q32))
			wrap = rem - ZW'(TWO_PI_Q32);
		else if (rem < -ZW'(PI_Q32))
			wrap = rem + ZW'(TWO_PI_Q32);
	end

	always_ff @(posedge clk) begin
		if (en)
			wrap_q <= wrap;
	end

	always_comb begin
		fold = wrap_q;
		fold_neg = 1'b0;
		if (wrap_q > ZW'(HALF_PI_Q32)) begin
			fold = ZW'(PI_Q32) - wrap_q;
			fold_neg = 1'b1;
		end else if (wrap_q < -ZW'(HALF_PI_Q32)) begin
			fold = -ZW'(PI_Q32) - wrap_q;
			fold_neg = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_c[0] <= XW'(GAIN_Q30);
			y_c[0] <= '0;
			z_c[0] <= fold;
			ng_c[0] <= fold_neg;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		localparam logic signed [ZW-1:0] ATAN = atan_q32(i);
		logic signed [XW-1:0] xs;
		logic signed [XW-1:0] ys;
		assign xs = x_c[i] >>> i;
		assign ys = y_c[i] >>> i;
		always_ff @(posedge clk) begin
			if (en) begin
				ng_c[i+1] <= ng_c[i];
				if (z_c[i] >= 0) begin
					x_c[i+1] <= x_c[i] - ys;
					y_c[i+1] <= y_c[i] + xs;
					z_c[i+1] <= z_c[i] - ATAN;
				end else begin
					x_c[i+1] <= x_c[i] + ys;
					y_c[i+1] <= y_c[i] - xs;
					z_c[i+1] <= z_c[i] + ATAN;
				end
			end
		end
	end

	assign cos_o = SCW'(ng_c[CORDIC_STEPS] ? -x_c[CORDIC_STEPS] : x_c[CORDIC_STEPS]);
	assign sin_o = SCW'(y_c[CORDIC_STEPS]);
endmodule

>>> hw/rtl/e2q_merge.sv
// ----------------------------------------------------------------------------
// e2q_merge: quaternion component merge
// Forms the triple products of the three lanes, adds them in pairs, rounds
// to the output format and saturates at plus or minus one.
// ----------------------------------------------------------------------------
module e2q_merge #(
	parameter int COMPONENT_FRAC_BITS = e2q_pkg::COMP_FRAC_DEF
) (
	input  logic clk,
	input  logic en,
	input  logic signed [e2q_pkg::SCW-1:0] c1,
	input  logic signed [e2q_pkg::SCW-1:0] s1,
	input  logic signed [e2q_pkg::SCW-1:0] c2,
	input  logic signed [e2q_pkg::SCW-1:0] s2,
	input  logic signed [e2q_pkg::SCW-1:0] c3,
	input  logic signed [e2q_pkg::SCW-1:0] s3,
	output logic [4*(COMPONENT_FRAC_BITS+2)-1:0] quat
);
	import e2q_pkg::*;

	localparam int CW = COMPONENT_FRAC_BITS + 2;
	localparam int SH = 60 - COMPONENT_FRAC_BITS;
	localparam int PW = 2 * SCW;
	localparam int RW = 34;
	localparam int TW = RW + SCW;
	localparam int SW = TW + 1;
	localparam logic signed [SW-1:0] ONE = SW'(1) <<< COMPONENT_FRAC_BITS;
	localparam logic signed [SW-1:0] HALF = SW'(1) <<< (SH - 1);
	localparam logic signed [PW-1:0] PHALF = PW'(1) <<< 29;

	// Pair products: s1c2, c1s2, c1c2, s1s2.
	logic signed [PW-1:0] p_s1 [4];
	logic signed [SCW-1:0] c3_s1, s3_s1;
	logic signed [RW-1:0] r [4];
	logic signed [TW-1:0] t_s2 [8];
	logic signed [SW-1:0] sum [4];
	logic signed [SW-1:0] rnd [4];
	logic [CW-1:0] sat [4];

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1[0] <= s1 * c2;
			p_s1[1] <= c1 * s2;
			p_s1[2] <= c1 * c2;
			p_s1[3] <= s1 * s2;
			c3_s1 <= c3;
			s3_s1 <= s3;
		end
	end

	for (genvar j = 0; j < 4; j++) begin : g_rnd
		logic signed [PW-1:0] pr;
		assign pr = (p_s1[j] + PHALF) >>> 30;
		assign r[j] = RW'(pr);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s2[0] <= r[0] * c3_s1;
			t_s2[1] <= r[1] * s3_s1;
			t_s2[2] <= r[1] * c3_s1;
			t_s2[3] <= r[0] * s3_s1;
			t_s2[4] <= r[2] * s3_s1;
			t_s2[5] <= r[3] * c3_s1;
			t_s2[6] <= r[2] * c3_s1;
			t_s2[7] <= r[3] * s3_s1;
		end
	end

	assign sum[0] = SW'(t_s2[0]) + SW'(t_s2[1]);
	assign sum[1] = SW'(t_s2[2]) - SW'(t_s2[3]);
	assign sum[2] = SW'(t_s2[4]) + SW'(t_s2[5]);
	assign sum[3] = SW'(t_s2[6]) - SW'(t_s2[7]);

	for (genvar j = 0; j < 4; j++) begin : g_sat
		assign rnd[j] = (sum[j] + HALF) >>> SH;
		always_comb begin
			if (rnd[j] > ONE)
				sat[j] = CW'(ONE);
			else if (rnd[j] < -ONE)
				sat[j] = CW'(-ONE);
			else
				sat[j] = CW'(rnd[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 4; j++)
				quat[j*CW +: CW] <= sat[j];
		end
	end
endmodule

>>> hw/rtl/euler_to_quaternion.sv
// ----------------------------------------------------------------------------
// euler_to_quaternion: X-Y-Z Euler angles to quaternion
// Three sine/cosine lanes feed a product-and-sum merge stage.
// ----------------------------------------------------------------------------
// One transaction in gives one quaternion out. The block is fully pipelined and
// takes a new transaction every cycle unless the output stalls. In each angle lane
// an input register, the range reduction stages, a wrap register, a CORDIC load
// register and one stage per CORDIC rotation lead into three merge stages. A
// result held at the output while m_tready is low stalls the whole pipeline.
// Angles are Q12 radians; components are Q(COMPONENT_FRAC_BITS), saturated to
// plus or minus one.
module euler_to_quaternion #(
	parameter int ANGLE_WIDTH = e2q_pkg::ANGLE_WIDTH_DEF,
	parameter int COMPONENT_FRAC_BITS = e2q_pkg::COMP_FRAC_DEF,
	parameter int CORDIC_STEPS = e2q_pkg::CORDIC_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// angle_x, angle_y, angle_z from the lowest bit up, zero padded to bytes
	input  logic [((3*ANGLE_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// quat_x, quat_y, quat_z, quat_w from the lowest bit up, zero padded to bytes
	output logic [((4*(COMPONENT_FRAC_BITS+2)+7)/8)*8-1:0] m_tdata
);
	import e2q_pkg::*;

	`include "assert_macros.svh"

	localparam int CW = COMPONENT_FRAC_BITS + 2;
	localparam int OW = ((4 * CW + 7) / 8) * 8;
	localparam int LAT = lane_latency(ANGLE_WIDTH, CORDIC_STEPS) + MERGE_LAT;

	logic en;
	logic [LAT-1:0] vld_q;
	logic signed [SCW-1:0] cs [3];
	logic signed [SCW-1:0] sn [3];
	logic [4*CW-1:0] quat;
	logic signed [CW-1:0] qx, qw;

	assign en = !vld_q[LAT-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	for (genvar l = 0; l < 3; l++) begin : g_lane
		e2q_sincos #(
			.ANGLE_WIDTH(ANGLE_WIDTH),
			.CORDIC_STEPS(CORDIC_STEPS)
		) u_lane (
			.clk(clk),
			.en(en),
			.angle(s_tdata[l*ANGLE_WIDTH +: ANGLE_WIDTH]),
			.cos_o(cs[l]),
			.sin_o(sn[l])
		);
	end

	e2q_merge #(
		.COMPONENT_FRAC_BITS(COMPONENT_FRAC_BITS)
	) u_merge (
		.clk(clk),
		.en(en),
		.c1(cs[0]),
		.s1(sn[0]),
		.c2(cs[1]),
		.s2(sn[1]),
		.c3(cs[2]),
		.s3(sn[2]),
		.quat(quat)
	);

	assign m_tdata = OW'(quat);
	assign qx = quat[CW-1:0];
	assign qw = quat[3*CW +: CW];

	`ASSERT_CLK(a_ready_when_empty, !m_tvalid |-> s_tready, "input stalled with empty output")
	`ASSERT_NEVER(a_qx_sat, m_tvalid && (qx > (CW'(1) <<< COMPONENT_FRAC_BITS) || qx < -(CW'(1) <<< COMPONENT_FRAC_BITS)), "quat_x beyond one")
	`ASSERT_NEVER(a_qw_sat, m_tvalid && (qw > (CW'(1) <<< COMPONENT_FRAC_BITS) || qw < -(CW'(1) <<< COMPONENT_FRAC_BITS)), "quat_w beyond one")
	`ASSERT_CLK(a_lane_bound, vld_q[LAT-1-MERGE_LAT] |-> (cs[0] <= 32'sd1073807360 && cs[0] >= -32'sd1073807360), "lane cosine out of range")
endmodule
